// ----- hdl/assert_macros.svh -----
// Assertion helpers used by rational_arith_unit.sv. Each macro expects a clock named clk
// and an active-low reset named rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/rau_pkg.sv -----
package rau_pkg;

  localparam logic [2:0] CMD_MAKE = 3'd0;
  localparam logic [2:0] CMD_NEG  = 3'd1;
  localparam logic [2:0] CMD_ADD  = 3'd2;
  localparam logic [2:0] CMD_SUB  = 3'd3;
  localparam logic [2:0] CMD_MUL  = 3'd4;
  localparam logic [2:0] CMD_DIV  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [1:0] OP_GCD = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  // Magnitude of the most negative 64-bit value.
  localparam logic [63:0] MIN_MAG = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } unit_req_t;

endpackage

// ----- hdl/rational_arith_unit.sv -----
// Exact rational arithmetic on 64-bit numerator/denominator pairs. One input word
// carries a command (make, negate, add, subtract, multiply, divide) and two fractions;
// one output word carries a status (ok, division by zero, overflow) and the reduced
// result with a positive denominator, or zeros on error. Every gcd, quotient and
// product runs through one shared iterative unit that does a binary gcd (one
// subtract or shift per cycle), a restoring divide or a shift-add multiply, driven
// by a small sequencer; the sum of the scaled numerators is formed outside it. How
// long a command takes depends on how long the gcd runs take; errors detected
// early finish sooner.
// The input is accepted only while the sequencer is idle, and a finished result waits
// in the output register, so the next word can be taken while it is still unread.
`include "assert_macros.svh"

module rational_arith_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[2:0], a_num[66:3], a_den[130:67], b_num[194:131], b_den[258:195], zero pad
  input  logic [263:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], result_num[65:2], result_den[128:66], zero pad
  output logic [135:0] out_tdata
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHKA = 5'd1;
  localparam logic [4:0] S_AFTA = 5'd2;
  localparam logic [4:0] S_CHKB = 5'd3;
  localparam logic [4:0] S_AFTB = 5'd4;
  localparam logic [4:0] S_RED  = 5'd5;
  localparam logic [4:0] S_RG   = 5'd6;
  localparam logic [4:0] S_RDN  = 5'd7;
  localparam logic [4:0] S_RDD  = 5'd8;
  localparam logic [4:0] S_G1   = 5'd9;
  localparam logic [4:0] S_D1   = 5'd10;
  localparam logic [4:0] S_D2   = 5'd11;
  localparam logic [4:0] S_G2   = 5'd12;
  localparam logic [4:0] S_D3   = 5'd13;
  localparam logic [4:0] S_D4   = 5'd14;
  localparam logic [4:0] S_M1   = 5'd15;
  localparam logic [4:0] S_M2   = 5'd16;
  localparam logic [4:0] S_SUM  = 5'd17;
  localparam logic [4:0] S_M3   = 5'd18;
  localparam logic [4:0] S_OUT  = 5'd19;

  logic [4:0]  state_r, state_nxt;
  logic [4:0]  ret_r, ret_nxt;
  logic        issued_r, issued_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [63:0] an_raw_r, an_raw_nxt, ad_raw_r, ad_raw_nxt;
  logic [63:0] bn_raw_r, bn_raw_nxt, bd_raw_r, bd_raw_nxt;

  // Operands and the working fraction, all kept as sign plus magnitude.
  logic        a_s_r, a_s_nxt, b_s_r, b_s_nxt, r_s_r, r_s_nxt;
  logic [63:0] a_nm_r, a_nm_nxt, a_dm_r, a_dm_nxt;
  logic [63:0] b_nm_r, b_nm_nxt, b_dm_r, b_dm_nxt;
  logic [63:0] r_nm_r, r_nm_nxt, r_dm_r, r_dm_nxt;
  logic [63:0] g_r, g_nxt, u1_r, u1_nxt, u2_r, u2_nxt, u3_r, u3_nxt, u4_r, u4_nxt;
  logic        t1_s_r, t1_s_nxt, t2_s_r, t2_s_nxt;
  logic [63:0] t1_m_r, t1_m_nxt, t2_m_r, t2_m_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [1:0]   out_status_r, out_status_nxt;
  logic [63:0]  out_num_r, out_num_nxt;
  logic [62:0]  out_den_r, out_den_nxt;

  rau_pkg::unit_req_t unit_req;
  logic [63:0]  unit_x, unit_y;
  logic         unit_done;
  logic [127:0] unit_res;

  logic in_acc;
  logic addsub;
  logic unit_state;

  // Raw operand classification, as done when a raw pair is normalized.
  logic        a_div0, a_zero, a_ovf, a_sign;
  logic [63:0] a_nmag, a_dmag;
  logic        b_div0, b_zero, b_ovf, b_sign;
  logic [63:0] b_nmag, b_dmag;

  // Product range checks against the signed 64-bit limits.
  logic [63:0] lim_pos, lim_neg;
  logic        p_ovf_a, p_ovf_b, p_ovf_ab, p_ovf_pos;

  // Signed sum of the two scaled numerators.
  logic        sum_same, sum_ge, sum_s;
  logic [64:0] sum_add, sum_m;
  logic [63:0] sum_diff;
  logic        sum_ovf;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign addsub    = (cmd_r == rau_pkg::CMD_ADD) || (cmd_r == rau_pkg::CMD_SUB);

  assign a_div0 = (ad_raw_r == 64'd0);
  assign a_zero = (an_raw_r == 64'd0);
  assign a_ovf  = ad_raw_r[63] && (ad_raw_r == rau_pkg::MIN_MAG || an_raw_r == rau_pkg::MIN_MAG);
  assign a_sign = an_raw_r[63] ^ ad_raw_r[63];
  assign a_nmag = an_raw_r[63] ? (~an_raw_r + 64'd1) : an_raw_r;
  assign a_dmag = ad_raw_r[63] ? (~ad_raw_r + 64'd1) : ad_raw_r;

  assign b_div0 = (bd_raw_r == 64'd0);
  assign b_zero = (bn_raw_r == 64'd0);
  assign b_ovf  = bd_raw_r[63] && (bd_raw_r == rau_pkg::MIN_MAG || bn_raw_r == rau_pkg::MIN_MAG);
  assign b_sign = bn_raw_r[63] ^ bd_raw_r[63];
  assign b_nmag = bn_raw_r[63] ? (~bn_raw_r + 64'd1) : bn_raw_r;
  assign b_dmag = bd_raw_r[63] ? (~bd_raw_r + 64'd1) : bd_raw_r;

  assign lim_pos   = rau_pkg::MIN_MAG - 64'd1;
  assign lim_neg   = rau_pkg::MIN_MAG;
  assign p_ovf_a   = (unit_res[127:64] != 64'd0) ||
                     (unit_res[63:0] > (a_s_r ? lim_neg : lim_pos));
  assign p_ovf_b   = (unit_res[127:64] != 64'd0) ||
                     (unit_res[63:0] > (b_s_r ? lim_neg : lim_pos));
  assign p_ovf_ab  = (unit_res[127:64] != 64'd0) ||
                     (unit_res[63:0] > ((a_s_r ^ b_s_r) ? lim_neg : lim_pos));
  assign p_ovf_pos = (unit_res[127:64] != 64'd0) || (unit_res[63:0] > lim_pos);

  assign sum_same = (t1_s_r == t2_s_r);
  assign sum_add  = {1'b0, t1_m_r} + {1'b0, t2_m_r};
  assign sum_ge   = (t1_m_r >= t2_m_r);
  assign sum_diff = sum_ge ? (t1_m_r - t2_m_r) : (t2_m_r - t1_m_r);
  assign sum_m    = sum_same ? sum_add : {1'b0, sum_diff};
  assign sum_s    = (sum_m != 65'd0) && (sum_same ? t1_s_r : (sum_ge ? t1_s_r : t2_s_r));
  assign sum_ovf  = sum_m > {1'b0, (sum_s ? lim_neg : lim_pos)};

  assign unit_state = (state_r == S_RG) || (state_r == S_RDN) || (state_r == S_RDD) ||
                      (state_r == S_G1) || (state_r == S_D1) || (state_r == S_D2) ||
                      (state_r == S_G2) || (state_r == S_D3) || (state_r == S_D4) ||
                      (state_r == S_M1) || (state_r == S_M2) || (state_r == S_M3);

  // Operand routing into the shared unit.
  always_comb begin
    unit_req.start = unit_state && !issued_r;
    unit_req.op    = rau_pkg::OP_DIV;
    unit_x         = r_nm_r;
    unit_y         = g_r;
    case (state_r)
      S_RG: begin
        unit_req.op = rau_pkg::OP_GCD;
        unit_x      = r_nm_r;
        unit_y      = r_dm_r;
      end
      S_RDN: begin
        unit_x = r_nm_r;
        unit_y = g_r;
      end
      S_RDD: begin
        unit_x = r_dm_r;
        unit_y = g_r;
      end
      S_G1: begin
        unit_req.op = rau_pkg::OP_GCD;
        unit_x      = addsub ? a_dm_r : a_nm_r;
        unit_y      = b_dm_r;
      end
      S_D1: begin
        unit_x = addsub ? a_dm_r : a_nm_r;
        unit_y = g_r;
      end
      S_D2: begin
        unit_x = b_dm_r;
        unit_y = g_r;
      end
      S_G2: begin
        unit_req.op = rau_pkg::OP_GCD;
        unit_x      = b_nm_r;
        unit_y      = a_dm_r;
      end
      S_D3: begin
        unit_x = b_nm_r;
        unit_y = g_r;
      end
      S_D4: begin
        unit_x = a_dm_r;
        unit_y = g_r;
      end
      S_M1: begin
        unit_req.op = rau_pkg::OP_MUL;
        unit_x      = addsub ? a_nm_r : u1_r;
        unit_y      = addsub ? u2_r : u3_r;
      end
      S_M2: begin
        unit_req.op = rau_pkg::OP_MUL;
        unit_x      = b_nm_r;
        unit_y      = u1_r;
      end
      S_M3: begin
        unit_req.op = rau_pkg::OP_MUL;
        unit_x      = addsub ? u1_r : u4_r;
        unit_y      = addsub ? b_dm_r : u2_r;
      end
      default: begin
        unit_req.op = rau_pkg::OP_DIV;
      end
    endcase
  end

  rau_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (unit_req),
    .x     (unit_x),
    .y     (unit_y),
    .done  (unit_done),
    .res   (unit_res)
  );

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    issued_nxt  = issued_r;
    err_nxt     = err_r;
    cmd_nxt     = cmd_r;
    an_raw_nxt  = an_raw_r;
    ad_raw_nxt  = ad_raw_r;
    bn_raw_nxt  = bn_raw_r;
    bd_raw_nxt  = bd_raw_r;
    a_s_nxt     = a_s_r;
    a_nm_nxt    = a_nm_r;
    a_dm_nxt    = a_dm_r;
    b_s_nxt     = b_s_r;
    b_nm_nxt    = b_nm_r;
    b_dm_nxt    = b_dm_r;
    r_s_nxt     = r_s_r;
    r_nm_nxt    = r_nm_r;
    r_dm_nxt    = r_dm_r;
    g_nxt       = g_r;
    u1_nxt      = u1_r;
    u2_nxt      = u2_r;
    u3_nxt      = u3_r;
    u4_nxt      = u4_r;
    t1_s_nxt    = t1_s_r;
    t1_m_nxt    = t1_m_r;
    t2_s_nxt    = t2_s_r;
    t2_m_nxt    = t2_m_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_num_nxt    = out_num_r;
    out_den_nxt    = out_den_r;

    if (unit_req.start) begin
      issued_nxt = 1'b1;
    end
    if (unit_done) begin
      issued_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_tdata[2:0];
          an_raw_nxt = in_tdata[66:3];
          ad_raw_nxt = in_tdata[130:67];
          bn_raw_nxt = in_tdata[194:131];
          bd_raw_nxt = in_tdata[258:195];
          err_nxt    = rau_pkg::ST_OK;
          state_nxt  = S_CHKA;
        end
      end
      S_CHKA: begin
        ret_nxt = S_AFTA;
        if (cmd_r > rau_pkg::CMD_DIV) begin
          err_nxt   = rau_pkg::ST_OVF;
          state_nxt = S_OUT;
        end else if (a_div0) begin
          err_nxt   = rau_pkg::ST_DIV0;
          state_nxt = S_OUT;
        end else if (a_zero) begin
          r_s_nxt   = 1'b0;
          r_nm_nxt  = 64'd0;
          state_nxt = S_RED;
        end else if (a_ovf) begin
          err_nxt   = rau_pkg::ST_OVF;
          state_nxt = S_OUT;
        end else begin
          r_s_nxt   = a_sign;
          r_nm_nxt  = a_nmag;
          r_dm_nxt  = a_dmag;
          state_nxt = S_RED;
        end
      end
      S_AFTA: begin
        a_s_nxt  = r_s_r;
        a_nm_nxt = r_nm_r;
        a_dm_nxt = r_dm_r;
        if (cmd_r == rau_pkg::CMD_MAKE) begin
          state_nxt = S_OUT;
        end else if (cmd_r == rau_pkg::CMD_NEG) begin
          // The only reduced values without a negation have the most negative numerator.
          if (r_s_r && r_nm_r == rau_pkg::MIN_MAG) begin
            err_nxt = rau_pkg::ST_OVF;
          end else begin
            r_s_nxt = !r_s_r && (r_nm_r != 64'd0);
          end
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CHKB;
        end
      end
      S_CHKB: begin
        ret_nxt = S_AFTB;
        if (b_div0) begin
          err_nxt   = rau_pkg::ST_DIV0;
          state_nxt = S_OUT;
        end else if (b_zero) begin
          r_s_nxt   = 1'b0;
          r_nm_nxt  = 64'd0;
          state_nxt = S_RED;
        end else if (b_ovf) begin
          err_nxt   = rau_pkg::ST_OVF;
          state_nxt = S_OUT;
        end else begin
          r_s_nxt   = b_sign;
          r_nm_nxt  = b_nmag;
          r_dm_nxt  = b_dmag;
          state_nxt = S_RED;
        end
      end
      S_AFTB: begin
        b_s_nxt   = r_s_r;
        b_nm_nxt  = r_nm_r;
        b_dm_nxt  = r_dm_r;
        state_nxt = S_G1;
        if (cmd_r == rau_pkg::CMD_DIV) begin
          // Divide multiplies by the reciprocal, which keeps the sign of b.
          if (r_nm_r == 64'd0) begin
            err_nxt   = rau_pkg::ST_DIV0;
            state_nxt = S_OUT;
          end else if (r_s_r && r_nm_r == rau_pkg::MIN_MAG) begin
            err_nxt   = rau_pkg::ST_OVF;
            state_nxt = S_OUT;
          end else begin
            b_nm_nxt = r_dm_r;
            b_dm_nxt = r_nm_r;
          end
        end
      end
      S_RED: begin
        if (r_nm_r == 64'd0) begin
          r_s_nxt   = 1'b0;
          r_dm_nxt  = 64'd1;
          state_nxt = ret_r;
        end else begin
          state_nxt = S_RG;
        end
      end
      S_RG: begin
        if (unit_done) begin
          g_nxt     = unit_res[63:0];
          state_nxt = S_RDN;
        end
      end
      S_RDN: begin
        if (unit_done) begin
          r_nm_nxt  = unit_res[63:0];
          state_nxt = S_RDD;
        end
      end
      S_RDD: begin
        if (unit_done) begin
          r_dm_nxt  = unit_res[63:0];
          state_nxt = ret_r;
        end
      end
      S_G1: begin
        if (unit_done) begin
          g_nxt     = unit_res[63:0];
          state_nxt = S_D1;
        end
      end
      S_D1: begin
        if (unit_done) begin
          u1_nxt    = unit_res[63:0];
          state_nxt = S_D2;
        end
      end
      S_D2: begin
        if (unit_done) begin
          u2_nxt    = unit_res[63:0];
          state_nxt = addsub ? S_M1 : S_G2;
        end
      end
      S_G2: begin
        if (unit_done) begin
          g_nxt     = unit_res[63:0];
          state_nxt = S_D3;
        end
      end
      S_D3: begin
        if (unit_done) begin
          u3_nxt    = unit_res[63:0];
          state_nxt = S_D4;
        end
      end
      S_D4: begin
        if (unit_done) begin
          u4_nxt    = unit_res[63:0];
          state_nxt = S_M1;
        end
      end
      S_M1: begin
        if (unit_done) begin
          if (addsub) begin
            if (p_ovf_a) begin
              err_nxt   = rau_pkg::ST_OVF;
              state_nxt = S_OUT;
            end else begin
              t1_s_nxt  = a_s_r;
              t1_m_nxt  = unit_res[63:0];
              state_nxt = S_M2;
            end
          end else begin
            if (p_ovf_ab) begin
              err_nxt   = rau_pkg::ST_OVF;
              state_nxt = S_OUT;
            end else begin
              r_s_nxt   = (a_s_r ^ b_s_r) && (unit_res[63:0] != 64'd0);
              r_nm_nxt  = unit_res[63:0];
              state_nxt = S_M3;
            end
          end
        end
      end
      S_M2: begin
        if (unit_done) begin
          if (p_ovf_b) begin
            err_nxt   = rau_pkg::ST_OVF;
            state_nxt = S_OUT;
          end else begin
            t2_s_nxt  = b_s_r ^ (cmd_r == rau_pkg::CMD_SUB);
            t2_m_nxt  = unit_res[63:0];
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (sum_ovf) begin
          err_nxt   = rau_pkg::ST_OVF;
          state_nxt = S_OUT;
        end else begin
          r_s_nxt   = sum_s;
          r_nm_nxt  = sum_m[63:0];
          state_nxt = S_M3;
        end
      end
      S_M3: begin
        if (unit_done) begin
          if (p_ovf_pos) begin
            err_nxt   = rau_pkg::ST_OVF;
            state_nxt = S_OUT;
          end else begin
            r_dm_nxt  = unit_res[63:0];
            ret_nxt   = S_OUT;
            state_nxt = S_RED;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = err_r;
          if (err_r == rau_pkg::ST_OK) begin
            out_num_nxt = r_s_r ? (~r_nm_r + 64'd1) : r_nm_r;
            out_den_nxt = r_dm_r[62:0];
          end else begin
            out_num_nxt = 64'd0;
            out_den_nxt = 63'd0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      issued_r    <= 1'b0;
      err_r       <= rau_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      issued_r    <= issued_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    an_raw_r     <= an_raw_nxt;
    ad_raw_r     <= ad_raw_nxt;
    bn_raw_r     <= bn_raw_nxt;
    bd_raw_r     <= bd_raw_nxt;
    a_s_r        <= a_s_nxt;
    a_nm_r       <= a_nm_nxt;
    a_dm_r       <= a_dm_nxt;
    b_s_r        <= b_s_nxt;
    b_nm_r       <= b_nm_nxt;
    b_dm_r       <= b_dm_nxt;
    r_s_r        <= r_s_nxt;
    r_nm_r       <= r_nm_nxt;
    r_dm_r       <= r_dm_nxt;
    g_r          <= g_nxt;
    u1_r         <= u1_nxt;
    u2_r         <= u2_nxt;
    u3_r         <= u3_nxt;
    u4_r         <= u4_nxt;
    t1_s_r       <= t1_s_nxt;
    t1_m_r       <= t1_m_nxt;
    t2_s_r       <= t2_s_nxt;
    t2_m_r       <= t2_m_nxt;
    out_status_r <= out_status_nxt;
    out_num_r    <= out_num_nxt;
    out_den_r    <= out_den_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_den_r, out_num_r, out_status_r};

  // The unit only reports completion for a request the sequencer is waiting on.
  `AST_SAME(a_done_issued, unit_done, issued_r && unit_state)
  // Error results carry an all-zero fraction.
  `AST_SAME(a_err_zero, out_valid_r && out_status_r != rau_pkg::ST_OK,
            out_num_r == 64'd0 && out_den_r == 63'd0)
  // A good result always has a nonzero denominator.
  `AST_SAME(a_ok_den, out_valid_r && out_status_r == rau_pkg::ST_OK, out_den_r != 63'd0)
  // An accepted word starts the sequencer.
  `AST_NEXT(a_acc_busy, in_acc, state_r == S_CHKA)

endmodule

// ----- hdl/rau_unit.sv -----
module rau_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  rau_pkg::unit_req_t req,
  input  logic [63:0]        x,
  input  logic [63:0]        y,
  output logic               done,
  output logic [127:0]       res
);

  logic         busy_r, busy_nxt;
  logic [1:0]   op_r, op_nxt;
  logic [63:0]  a_r, a_nxt;
  logic [63:0]  b_r, b_nxt;
  logic [63:0]  rem_r, rem_nxt;
  logic [127:0] p_r, p_nxt;
  logic [5:0]   k_r, k_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic         done_r, done_nxt;
  logic [127:0] res_r, res_nxt;

  logic [64:0]  div_sh;
  logic         div_ge;
  logic [64:0]  mul_sum;
  logic [63:0]  gcd_keep;

  assign div_sh   = {rem_r, a_r[63]};
  assign div_ge   = div_sh >= {1'b0, b_r};
  assign mul_sum  = {1'b0, p_r[127:64]} + (p_r[0] ? {1'b0, b_r} : 65'd0);
  assign gcd_keep = (a_r == 64'd0) ? b_r : a_r;

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    p_nxt    = p_r;
    k_nxt    = k_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    if (!busy_r) begin
      if (req.start) begin
        busy_nxt = 1'b1;
        op_nxt   = req.op;
        a_nxt    = x;
        b_nxt    = y;
        rem_nxt  = 64'd0;
        p_nxt    = {64'd0, x};
        k_nxt    = 6'd0;
        cnt_nxt  = 6'd0;
      end
    end else begin
      case (op_r)
        rau_pkg::OP_GCD: begin
          if (a_r == 64'd0 || b_r == 64'd0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            res_nxt  = {64'd0, gcd_keep << k_r};
          end else if (!a_r[0] && !b_r[0]) begin
            a_nxt = a_r >> 1;
            b_nxt = b_r >> 1;
            k_nxt = k_r + 6'd1;
          end else if (!a_r[0]) begin
            a_nxt = a_r >> 1;
          end else if (!b_r[0]) begin
            b_nxt = b_r >> 1;
          end else if (a_r >= b_r) begin
            a_nxt = a_r - b_r;
          end else begin
            b_nxt = b_r - a_r;
          end
        end
        rau_pkg::OP_DIV: begin
          rem_nxt = div_ge ? div_sh[63:0] - b_r : div_sh[63:0];
          a_nxt   = {a_r[62:0], div_ge};
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            res_nxt  = {64'd0, a_r[62:0], div_ge};
          end
        end
        rau_pkg::OP_MUL: begin
          p_nxt   = {mul_sum, p_r[63:1]};
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            res_nxt  = {mul_sum, p_r[63:1]};
          end
        end
        default: begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          res_nxt  = 128'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    p_r   <= p_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
